// File: hdl/scba_pkg.sv
// Shared types, constants and helpers for the size-class bitmap allocator.
package scba_pkg;

    localparam int MAX_CELL_LOG2    = 12;
    localparam int ARENAS_PER_CLASS = 8;
    localparam int CELLS_PER_ARENA  = 32;
    localparam int MIN_CELL_LOG2    = 3;
    localparam int SLOT_STRIDE      = 32;
    localparam int NUM_CLASSES      = MAX_CELL_LOG2 - MIN_CELL_LOG2 + 1;
    localparam int NUM_SLOTS        = NUM_CLASSES * ARENAS_PER_CLASS;

    localparam int SIZE_W   = 16;
    localparam int HANDLE_W = 12;
    localparam int BYTES_W  = 13;
    localparam int STATUS_W = 3;
    localparam int CELL_W   = $clog2(SLOT_STRIDE);
    localparam int SLOT_W   = HANDLE_W - CELL_W;
    localparam int CLS_W    = $clog2(NUM_CLASSES);
    localparam int ARENA_W  = (ARENAS_PER_CLASS > 1) ? $clog2(ARENAS_PER_CLASS) : 1;
    localparam int LG_W     = $clog2(SIZE_W + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 3'd4;

    typedef struct packed {
        logic                action;
        logic [SIZE_W-1:0]   request_size;
        logic [HANDLE_W-1:0] free_handle;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] granted_handle;
        logic [BYTES_W-1:0]  cell_bytes;
    } rsp_item_t;

    // Classified command handed from front to back.
    typedef struct packed {
        logic                is_free;
        logic [STATUS_W-1:0] status;
        logic [CLS_W-1:0]    cls;
        logic [SLOT_W-1:0]   slot;
        logic [CELL_W-1:0]   cell_idx;
    } cmd_t;

    // Mask of usable cells in one arena of class cls.
    function automatic logic [SLOT_STRIDE-1:0] cap_mask(input logic [CLS_W-1:0] cls);
        int lc;
        int cap;
        logic [SLOT_STRIDE-1:0] m;
        lc = MAX_CELL_LOG2 - MIN_CELL_LOG2 - int'(cls);
        if (lc < 0)
            lc = 0;
        cap = (lc >= 7) ? 128 : (1 << lc);
        if (cap > CELLS_PER_ARENA)
            cap = CELLS_PER_ARENA;
        if (cap > SLOT_STRIDE)
            cap = SLOT_STRIDE;
        for (int i = 0; i < SLOT_STRIDE; i++)
            m[i] = (i < cap);
        return m;
    endfunction

endpackage

// File: hdl/scba_front.sv
// Request classifier: size class, handle decode and early error checks.
module scba_front
    import scba_pkg::*;
(
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      push_valid,
    input  logic      push_ready,
    output cmd_t      push_cmd
);

    logic [SIZE_W-1:0] size_m1;
    logic [LG_W-1:0]   lg;
    logic [SLOT_W-1:0] slot;
    logic [CELL_W-1:0] cell_idx;
    logic [CLS_W-1:0]  cls_f;
    logic [SLOT_STRIDE-1:0] mask_f;

    assign req_ready  = push_ready;
    assign push_valid = req_valid;

    always_comb
    begin
        size_m1 = req.request_size - SIZE_W'(1);
        lg      = LG_W'(MIN_CELL_LOG2);
        // ceil(log2(size)), at least the minimum class
        for (int i = 0; i < SIZE_W; i++)
        begin
            if (size_m1[i] && (i + 1 > MIN_CELL_LOG2))
                lg = LG_W'(i + 1);
        end
        slot     = req.free_handle[HANDLE_W-1:CELL_W];
        cell_idx = req.free_handle[CELL_W-1:0];
        cls_f    = CLS_W'(slot / ARENAS_PER_CLASS);
        mask_f   = cap_mask(cls_f);

        push_cmd = '0;
        if (req.action == ACT_FREE)
        begin
            push_cmd.is_free  = 1'b1;
            push_cmd.slot     = slot;
            push_cmd.cell_idx = cell_idx;
            push_cmd.cls      = cls_f;
            if (32'(slot) >= NUM_SLOTS || !mask_f[cell_idx])
                push_cmd.status = ST_BAD_FREE;
            else
                push_cmd.status = ST_OK;
        end
        else
        begin
            if (req.request_size == '0)
                push_cmd.status = ST_ZERO;
            else if (32'(req.request_size) > (32'd1 << MAX_CELL_LOG2))
                push_cmd.status = ST_TOO_LARGE;
            else
            begin
                push_cmd.status = ST_OK;
                push_cmd.cls    = CLS_W'(lg - LG_W'(MIN_CELL_LOG2));
            end
        end
    end

endmodule

// File: hdl/scba_queue.sv
// Small command queue between the classifier and the execution engine.
module scba_queue
    import scba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: hdl/scba_back.sv
// Execution engine: bitmap memory, arena scan and result register.
module scba_back
    import scba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_CHK  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cur_reg, cur_next;
    logic [SLOT_W-1:0]  addr_reg, addr_next;
    logic [ARENA_W-1:0] arena_reg, arena_next;
    logic               out_valid_reg, out_valid_next;
    rsp_item_t          out_reg, out_next;
    logic               out_load;

    logic [SLOT_STRIDE-1:0] bitmap_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   written_reg;
    logic [SLOT_STRIDE-1:0] rd_data_reg;
    logic                   rd_written_reg;

    logic [SLOT_STRIDE-1:0] bits;
    logic [SLOT_STRIDE-1:0] free_bits;
    logic [CELL_W-1:0]      low_idx;
    logic                   wr_en;
    logic [SLOT_STRIDE-1:0] wr_data;
    logic [BYTES_W-1:0]     cls_bytes;

    assign cmd_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // never-written arenas read as empty
    assign bits      = rd_written_reg ? rd_data_reg : '0;
    assign free_bits = ~bits & cap_mask(cur_reg.cls);
    assign cls_bytes = BYTES_W'(1) << (int'(cur_reg.cls) + MIN_CELL_LOG2);

    always_comb
    begin
        low_idx = '0;
        for (int i = SLOT_STRIDE - 1; i >= 0; i--)
        begin
            if (free_bits[i])
                low_idx = CELL_W'(i);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        addr_next      = addr_reg;
        arena_next     = arena_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        out_load       = 1'b0;
        wr_en          = 1'b0;
        wr_data        = bits;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    if (cmd.status != ST_OK)
                    begin
                        out_load = 1'b1;
                        out_next = '{status: cmd.status, granted_handle: '0, cell_bytes: '0};
                    end
                    else
                    begin
                        cur_next   = cmd;
                        arena_next = '0;
                        addr_next  = cmd.is_free ? cmd.slot
                                   : SLOT_W'(int'(cmd.cls) * ARENAS_PER_CLASS);
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (cur_reg.is_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (!bits[cur_reg.cell_idx])
                        out_next = '{status: ST_BAD_FREE, granted_handle: '0, cell_bytes: '0};
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_data  = bits & ~(SLOT_STRIDE'(1) << cur_reg.cell_idx);
                        out_next = '{status: ST_OK, granted_handle: '0, cell_bytes: cls_bytes};
                    end
                end
                else if (free_bits != '0)
                begin
                    wr_en      = 1'b1;
                    wr_data    = bits | (SLOT_STRIDE'(1) << low_idx);
                    out_load   = 1'b1;
                    out_next   = '{status: ST_OK, granted_handle: {addr_reg, low_idx},
                                   cell_bytes: cls_bytes};
                    state_next = S_IDLE;
                end
                else if (arena_reg == ARENA_W'(ARENAS_PER_CLASS - 1))
                begin
                    out_load   = 1'b1;
                    out_next   = '{status: ST_FULL, granted_handle: '0, cell_bytes: '0};
                    state_next = S_IDLE;
                end
                else
                begin
                    arena_next = arena_reg + 1'b1;
                    addr_next  = addr_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            arena_reg      <= '0;
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            arena_reg      <= arena_next;
            rd_written_reg <= written_reg[addr_reg];
            if (wr_en)
                written_reg[addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        addr_reg <= addr_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            bitmap_mem[addr_reg] <= wr_data;
        rd_data_reg <= bitmap_mem[addr_reg];
    end

    // Result register stays empty while a command is being executed.
    a_no_result_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending during execution");

    // A memory read is always followed by its evaluation.
    a_rd_then_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |=> (state_reg == S_CHK))
        else $error("read not followed by check");

    // Error results carry no handle and no size.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != ST_OK)
            |-> (out_reg.granted_handle == '0 && out_reg.cell_bytes == '0))
        else $error("error result with payload");

    // Successful results always report a cell size.
    a_ok_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == ST_OK) |-> (out_reg.cell_bytes != '0))
        else $error("ok result without cell size");

    // Memory is written only from the check state.
    a_wr_in_chk: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_CHK))
        else $error("memory write outside check");

endmodule

// File: hdl/size_class_bitmap_allocator_top.sv
// Top level of the size-class bitmap allocator.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------
//  req     | in        | req_valid / req_ready    | action, request_size, free_handle
//  rsp     | out       | rsp_valid / rsp_ready    | status, granted_handle, cell_bytes
//
// Steps: a free reads and checks the bitmap of its own arena; an allocation
// scans N arenas, N the number of arenas scanned (1..ARENAS_PER_CLASS), one
// bitmap memory read and check per arena. Requests failing early checks go straight to the result.
// Reset clears the queue, the engine and the per-arena written flags; arenas
// never written read as empty, so no clearing pass is needed.
// Stalls: the 2-deep command queue accepts until full while the engine works
// or a result waits; the engine takes the next command once the result is taken.
module size_class_bitmap_allocator_top
    import scba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    // front -> queue
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;

    // queue -> back
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    // classify: size class, handle decode, zero/too-large/range checks
    scba_front u_front (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // decouples acceptance from execution
    scba_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // bitmap memory, first-fit arena scan, result register
    scba_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
